>>> sv/dcld_pkg.sv
// Package for the delimited command line decoder: keyword table, result codes and types.
// Used by every module of the block; depends on nothing else.
package dcld_pkg;

    localparam int KEYWORD_COUNT   = 17;
    localparam int KEYWORD_MAX_LEN = 19;
    localparam int POS_W           = 5;
    localparam int POS_COUNT       = 2 ** POS_W;
    localparam int CODE_W          = 5;
    localparam int ARGC_W          = 2;
    localparam int STATUS_W        = 2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [CODE_W-1:0]   NO_MATCH       = CODE_W'(KEYWORD_COUNT);
    localparam logic [ARGC_W-1:0]   ARGC_MAX       = '1;
    localparam logic [POS_W-1:0]    POS_MAX        = '1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ARGS    = 2'd3;

    localparam logic KIND_ARG     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Result queue sizing: room for the two results of one byte on top of two waiting.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef logic [8*KEYWORD_MAX_LEN-1:0] kw_text_t;

    // Several keywords share a stem, so they are assembled from their parts.
    localparam kw_text_t KW_TEXT [KEYWORD_COUNT] = '{
        "say", "nick", "response", "login", "register",
        {"friend", "_request"}, {"friend", "_accept"}, {"friend", "_reject"},
        {"friend", "_remove"}, {"list_", "friend"}, {"list_", "friend", "_request"},
        {"create", "_room"}, {"delete", "_room"}, {"invite", "_room"},
        {"leave", "_room"}, "list_room", "history"
    };

    localparam logic [POS_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
        5'd3, 5'd4, 5'd8, 5'd5, 5'd8, 5'd14, 5'd13, 5'd13, 5'd13, 5'd11,
        5'd19, 5'd11, 5'd11, 5'd11, 5'd10, 5'd9, 5'd7
    };

    localparam logic [ARGC_W-1:0] KW_ARGS [KEYWORD_COUNT] = '{
        2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0,
        2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2
    };

    typedef logic [POS_COUNT-1:0][7:0]      kw_row_t;
    typedef kw_row_t [KEYWORD_COUNT-1:0]    kw_rom_t;

    // Character of each keyword at each position, zero past its end.
    function automatic kw_rom_t build_kw_rom();
        kw_rom_t rom;
        int      len;
        rom = '0;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            len = int'(KW_LEN[k]);
            for (int p = 0; p < POS_COUNT; p++) begin
                if (p < len) begin
                    rom[k][p] = KW_TEXT[k][8*(len-1-p) +: 8];
                end
            end
        end
        return rom;
    endfunction

    localparam kw_rom_t KW_ROM = build_kw_rom();

    typedef struct packed {
        logic                result_kind;
        logic                arg_index;
        logic [7:0]          arg_byte;
        logic [CODE_W-1:0]   command_code;
        logic [STATUS_W-1:0] status;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic arg_valid;
        logic verdict_valid;
    } push_t;

endpackage

>>> sv/dcld_decode.sv
// Line state and per-byte decoding: keyword matching, argument tagging and the verdict.
// Depends on dcld_pkg.
module dcld_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  logic [7:0]          item_byte,
    input  logic                item_eol,
    output dcld_pkg::result_t   arg_result,
    output dcld_pkg::result_t   verdict_result,
    output dcld_pkg::push_t     push
);

    logic                                in_token_reg, in_token_next;
    logic                                after_return_reg, after_return_next;
    logic                                command_seen_reg, command_seen_next;
    logic [dcld_pkg::KEYWORD_COUNT-1:0]  keyword_mask_reg, keyword_mask_next;
    logic [dcld_pkg::POS_W-1:0]          char_position_reg, char_position_next;
    logic [dcld_pkg::CODE_W-1:0]         matched_keyword_reg, matched_keyword_next;
    logic [dcld_pkg::ARGC_W-1:0]         arg_count_reg, arg_count_next;

    logic                                drop_final, skip_lf, is_cr;
    logic                                token_byte, cr_split, starting;
    logic                                cmd_step, in_tok_mid, do_find;
    logic [dcld_pkg::ARGC_W-1:0]         argc_step;
    logic [dcld_pkg::KEYWORD_COUNT-1:0]  mask_step;
    logic [dcld_pkg::POS_W-1:0]          pos_step;
    logic [dcld_pkg::CODE_W-1:0]         found, matched_step;
    logic [dcld_pkg::ARGC_W-1:0]         want_args;
    logic                                arg_out;

    always_comb begin
        drop_final = item_eol && (item_byte == dcld_pkg::CH_LF);
        skip_lf    = after_return_reg && (item_byte == dcld_pkg::CH_LF);
        is_cr      = (item_byte == dcld_pkg::CH_CR);
        token_byte = !drop_final && !skip_lf && !is_cr;
        cr_split   = !drop_final && !skip_lf && is_cr;
        starting   = token_byte && !in_token_reg;
        cmd_step   = command_seen_reg | starting;

        argc_step = arg_count_reg;
        if (starting && command_seen_reg && (arg_count_reg != dcld_pkg::ARGC_MAX)) begin
            argc_step = arg_count_reg + 1'b1;
        end
        in_tok_mid = in_token_reg | token_byte;

        // The command token narrows the mask one byte at a time.
        mask_step = keyword_mask_reg;
        pos_step  = char_position_reg;
        if (token_byte && (argc_step == '0)) begin
            for (int k = 0; k < dcld_pkg::KEYWORD_COUNT; k++) begin
                mask_step[k] = keyword_mask_reg[k]
                    && (char_position_reg < dcld_pkg::KW_LEN[k])
                    && (dcld_pkg::KW_ROM[k][char_position_reg] == item_byte);
            end
            if (char_position_reg != dcld_pkg::POS_MAX) begin
                pos_step = char_position_reg + 1'b1;
            end
        end

        // The lowest surviving keyword whose length equals the token length wins.
        found = dcld_pkg::NO_MATCH;
        for (int k = dcld_pkg::KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (mask_step[k] && (dcld_pkg::KW_LEN[k] == pos_step)) begin
                found = dcld_pkg::CODE_W'(k);
            end
        end
        do_find      = (cr_split || item_eol) && in_tok_mid && (argc_step == '0);
        matched_step = do_find ? found : matched_keyword_reg;

        want_args = '0;
        for (int k = 0; k < dcld_pkg::KEYWORD_COUNT; k++) begin
            if (matched_step == dcld_pkg::CODE_W'(k)) begin
                want_args = dcld_pkg::KW_ARGS[k];
            end
        end

        arg_out = token_byte && (argc_step != '0) && (argc_step != dcld_pkg::ARGC_MAX);

        arg_result              = '0;
        arg_result.result_kind  = dcld_pkg::KIND_ARG;
        arg_result.arg_index    = (argc_step == 2'd2);
        arg_result.arg_byte     = item_byte;
        arg_result.last_of_run  = !item_eol;

        verdict_result              = '0;
        verdict_result.result_kind  = dcld_pkg::KIND_VERDICT;
        verdict_result.last_of_run  = 1'b1;
        if (!cmd_step) begin
            verdict_result.status = dcld_pkg::STATUS_EMPTY;
        end else if (matched_step >= dcld_pkg::NO_MATCH) begin
            verdict_result.status = dcld_pkg::STATUS_INVALID;
        end else begin
            verdict_result.command_code = matched_step;
            verdict_result.status = (want_args == argc_step) ? dcld_pkg::STATUS_OK
                                                             : dcld_pkg::STATUS_ARGS;
        end

        push.arg_valid     = item_valid && arg_out;
        push.verdict_valid = item_valid && item_eol;

        in_token_next        = in_token_reg;
        after_return_next    = after_return_reg;
        command_seen_next    = command_seen_reg;
        keyword_mask_next    = keyword_mask_reg;
        char_position_next   = char_position_reg;
        matched_keyword_next = matched_keyword_reg;
        arg_count_next       = arg_count_reg;
        if (item_valid) begin
            if (item_eol) begin
                in_token_next        = 1'b0;
                after_return_next    = 1'b0;
                command_seen_next    = 1'b0;
                keyword_mask_next    = '1;
                char_position_next   = '0;
                matched_keyword_next = dcld_pkg::NO_MATCH;
                arg_count_next       = '0;
            end else begin
                in_token_next        = token_byte ? 1'b1 : (cr_split ? 1'b0 : in_token_reg);
                after_return_next    = is_cr;
                command_seen_next    = cmd_step;
                keyword_mask_next    = mask_step;
                char_position_next   = pos_step;
                matched_keyword_next = matched_step;
                arg_count_next       = argc_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg        <= 1'b0;
            after_return_reg    <= 1'b0;
            command_seen_reg    <= 1'b0;
            keyword_mask_reg    <= '1;
            char_position_reg   <= '0;
            matched_keyword_reg <= dcld_pkg::NO_MATCH;
            arg_count_reg       <= '0;
        end else begin
            in_token_reg        <= in_token_next;
            after_return_reg    <= after_return_next;
            command_seen_reg    <= command_seen_next;
            keyword_mask_reg    <= keyword_mask_next;
            char_position_reg   <= char_position_next;
            matched_keyword_reg <= matched_keyword_next;
            arg_count_reg       <= arg_count_next;
        end
    end

    a_line_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item_eol) |=> (!command_seen_reg && (arg_count_reg == '0)
            && (keyword_mask_reg == '1) && (matched_keyword_reg == dcld_pkg::NO_MATCH)))
        else $error("line state not cleared after the last byte");

    a_argc_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_valid && item_eol) |=> (arg_count_reg >= $past(arg_count_reg)))
        else $error("argument count fell within a line");

    a_args_need_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (arg_count_reg != '0) |-> command_seen_reg)
        else $error("argument counted before any command token");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.verdict_valid && ((verdict_result.status == dcld_pkg::STATUS_EMPTY)
            || (verdict_result.status == dcld_pkg::STATUS_INVALID)))
        |-> (verdict_result.command_code == '0))
        else $error("command code set on an empty or invalid line");

endmodule

>>> sv/dcld_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on dcld_pkg.
module dcld_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  dcld_pkg::push_t     push,
    input  dcld_pkg::result_t   arg_result,
    input  dcld_pkg::result_t   verdict_result,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output dcld_pkg::result_t   out_result
);

    dcld_pkg::result_t                entries_reg [dcld_pkg::OUT_DEPTH];
    logic [dcld_pkg::OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dcld_pkg::OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dcld_pkg::OUT_CNT_W-1:0]   count_reg, count_next;
    logic [dcld_pkg::OUT_PTR_W-1:0]   wr_ptr_plus;
    logic [dcld_pkg::OUT_CNT_W-1:0]   n_push;
    logic                             pop;
    dcld_pkg::result_t                first_result;

    always_comb begin
        n_push       = dcld_pkg::OUT_CNT_W'(push.arg_valid)
                     + dcld_pkg::OUT_CNT_W'(push.verdict_valid);
        pop          = out_valid && out_ready;
        first_result = push.arg_valid ? arg_result : verdict_result;
        wr_ptr_plus  = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + dcld_pkg::OUT_PTR_W'(n_push);
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + n_push - dcld_pkg::OUT_CNT_W'(pop);
    end

    // Room is judged on the registered count alone, so the sink's ready never reaches s_tready.
    assign room       = (count_reg <= dcld_pkg::OUT_CNT_W'(dcld_pkg::OUT_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_result = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (n_push != '0) begin
            entries_reg[wr_ptr_reg] <= first_result;
        end
        if (push.arg_valid && push.verdict_valid) begin
            entries_reg[wr_ptr_plus] <= verdict_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_push + count_reg) <= dcld_pkg::OUT_CNT_W'(dcld_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg < dcld_pkg::OUT_CNT_W'(dcld_pkg::OUT_DEPTH))
        |-> (dcld_pkg::OUT_PTR_W'(wr_ptr_reg - rd_ptr_reg)
             == dcld_pkg::OUT_PTR_W'(count_reg)))
        else $error("queue pointers disagree with the fill count");

endmodule

>>> sv/delimited_command_line_decoder.sv
// Top level of the delimited command line decoder: input register, decoder and result queue.
// Depends on dcld_pkg, dcld_decode and dcld_result_fifo.
//
// Usage: command line bytes enter on the s_ channel, one per transaction, with s_tlast on
// the final byte of a line. Carriage returns split tokens; the first token is matched
// against the keyword table. Bytes of the first two arguments leave on the m_ channel as
// argument results (m_tuser low); the last byte of a line also yields a verdict (m_tuser
// high) carrying the command code and status. m_tlast marks the final result of a byte.
// A byte passes through the input register and then the result queue before its results
// appear on the m_ channel. Throughput: one byte per cycle while the queue has room; a
// line-end byte that is also an argument byte puts two results on the m_ channel, which
// drains them one per cycle while m_tready is high. The four-entry result queue lets the
// input keep flowing while a result waits, and s_tready falls only once the queue holds
// three or more results, so stalls at the sink propagate back after that slack is used.
// Reset (aresetn low, synchronous) empties the queue and clears the line state, so the
// next byte starts a fresh line.
module delimited_command_line_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] arg_index, [8:1] arg_byte, [13:9] command_code,
                                   // [15:14] status
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast    // last_of_run
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_eol_reg;
    logic               take;
    logic               room;
    dcld_pkg::result_t  arg_result;
    dcld_pkg::result_t  verdict_result;
    dcld_pkg::push_t    push;
    dcld_pkg::result_t  out_result;

    assign take     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    dcld_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (take),
        .item_byte      (in_byte_reg),
        .item_eol       (in_eol_reg),
        .arg_result     (arg_result),
        .verdict_result (verdict_result),
        .push           (push)
    );

    dcld_result_fifo u_result_fifo (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (push),
        .arg_result     (arg_result),
        .verdict_result (verdict_result),
        .room           (room),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_result     (out_result)
    );

    assign m_tdata = {out_result.status, out_result.command_code,
                      out_result.arg_byte, out_result.arg_index};
    assign m_tuser = out_result.result_kind;
    assign m_tlast = out_result.last_of_run;

endmodule

>>> bench/delimited_command_line_decoder_tb.sv
// Self-checking bench for the delimited command line decoder: a queue-fed driver streams
// command lines, and a monitor compares each result with a line-state predictor.
// Depends on dcld_pkg and the delimited_command_line_decoder top level.
module delimited_command_line_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTE_TARGET = 1950;
    localparam int CALM_FROM        = 1500;
    localparam int CALM_TO          = 3000;
    localparam int TAIL_CYCLES      = 20;
    localparam int REPORT_LIMIT     = 10;

    localparam string STEM_FRIEND = "friend";
    localparam string STEM_LIST   = "list_";
    localparam string STEM_ROOM   = "_room";

    typedef struct packed {
        logic [7:0] data;
        logic       eol;
    } line_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    line_byte_t          line_bytes [$];
    dcld_pkg::result_t   due_results [$];
    int                  fail_count = 0;
    int unsigned         cycle_no   = 0;

    string keywords [dcld_pkg::KEYWORD_COUNT] = '{
        "say", "nick", "response", "login", "register",
        {STEM_FRIEND, "_request"}, {STEM_FRIEND, "_accept"}, {STEM_FRIEND, "_reject"},
        {STEM_FRIEND, "_remove"}, {STEM_LIST, STEM_FRIEND},
        {STEM_LIST, STEM_FRIEND, "_request"}, {"create", STEM_ROOM},
        {"delete", STEM_ROOM}, {"invite", STEM_ROOM}, {"leave", STEM_ROOM},
        "list_room", "history"
    };
    int wanted_args [dcld_pkg::KEYWORD_COUNT] = '{
        2, 1, 1, 2, 2, 1, 1, 1, 1, 0, 0, 1, 1, 2, 1, 0, 2
    };

    // Line state of the predictor.
    logic                        tok_open;
    logic                        after_cr;
    logic                        cmd_started;
    logic [1:0]                  argc;
    logic [dcld_pkg::CODE_W-1:0] cmd_kw;
    byte unsigned                cmd_token [$];

    delimited_command_line_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    function automatic bit take_break();
        if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 30;
    endfunction

    function automatic void clear_line_state();
        tok_open    = 1'b0;
        after_cr    = 1'b0;
        cmd_started = 1'b0;
        argc        = '0;
        cmd_kw      = dcld_pkg::NO_MATCH;
        cmd_token.delete();
    endfunction

    // Closing the command token decides which keyword, if any, it spells exactly.
    function automatic void close_token();
        bit same;
        if (tok_open && argc == 0) begin
            cmd_kw = dcld_pkg::NO_MATCH;
            for (int k = 0; k < dcld_pkg::KEYWORD_COUNT; k++) begin
                same = (cmd_token.size() == keywords[k].len());
                for (int p = 0; same && p < cmd_token.size(); p++) begin
                    same = (cmd_token[p] == keywords[k][p]);
                end
                if (same) begin
                    cmd_kw = dcld_pkg::CODE_W'(k);
                    break;
                end
            end
        end
        tok_open = 1'b0;
    endfunction

    function automatic void decode_line_byte(input logic [7:0] b, input logic eol);
        dcld_pkg::result_t outs [$];
        dcld_pkg::result_t r;
        if (eol && b == dcld_pkg::CH_LF) begin
            // A newline that ends the line carries no content.
        end else if (after_cr && b == dcld_pkg::CH_LF) begin
            // One newline straight after a carriage return is swallowed.
        end else if (b == dcld_pkg::CH_CR) begin
            close_token();
        end else begin
            if (!tok_open) begin
                tok_open = 1'b1;
                if (!cmd_started) begin
                    cmd_started = 1'b1;
                end else if (argc < 3) begin
                    argc = argc + 2'd1;
                end
            end
            if (argc == 0) begin
                cmd_token.push_back(b);
            end else if (argc <= 2) begin
                r             = '0;
                r.result_kind = dcld_pkg::KIND_ARG;
                r.arg_index   = (argc == 2'd2);
                r.arg_byte    = b;
                outs.push_back(r);
            end
        end
        after_cr = (b == dcld_pkg::CH_CR);

        if (eol) begin
            close_token();
            r             = '0;
            r.result_kind = dcld_pkg::KIND_VERDICT;
            if (!cmd_started) begin
                r.status = dcld_pkg::STATUS_EMPTY;
            end else if (cmd_kw == dcld_pkg::NO_MATCH) begin
                r.status = dcld_pkg::STATUS_INVALID;
            end else begin
                r.command_code = cmd_kw;
                r.status = (wanted_args[cmd_kw] == int'(argc)) ? dcld_pkg::STATUS_OK
                                                               : dcld_pkg::STATUS_ARGS;
            end
            outs.push_back(r);
            clear_line_state();
        end

        if (outs.size() > 0) begin
            outs[outs.size()-1].last_of_run = 1'b1;
        end
        foreach (outs[i]) begin
            due_results.push_back(outs[i]);
        end
    endfunction

    // Queues one line, with the end-of-line flag on its final byte.
    function automatic int queue_line(input byte unsigned ln [$]);
        line_byte_t t;
        foreach (ln[i]) begin
            t.data = ln[i];
            t.eol  = (i == ln.size() - 1);
            line_bytes.push_back(t);
        end
        return ln.size();
    endfunction

    function automatic int queue_text(input string s);
        byte unsigned ln [$];
        for (int i = 0; i < s.len(); i++) begin
            ln.push_back(s[i]);
        end
        return queue_line(ln);
    endfunction

    function automatic byte unsigned plain_byte();
        byte unsigned c;
        c = 8'($urandom_range(0, 255));
        if (c == dcld_pkg::CH_CR || c == dcld_pkg::CH_LF) begin
            c = 8'h5F;
        end
        return c;
    endfunction

    // Mostly well-formed commands with random arguments; the rest is noise.
    function automatic int queue_random_line();
        byte unsigned ln [$];
        byte unsigned word [$];
        int           k;
        int           nargs;
        int           r;
        bit           cr_heavy;
        if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) ln.push_back(dcld_pkg::CH_CR);
            end
            k = $urandom_range(0, dcld_pkg::KEYWORD_COUNT - 1);
            for (int i = 0; i < keywords[k].len(); i++) begin
                word.push_back(keywords[k][i]);
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: word[$urandom_range(0, word.size() - 1)] = 8'($urandom_range(97, 122));
                    1: void'(word.pop_back());
                    default: word.push_back(8'($urandom_range(97, 122)));
                endcase
            end
            foreach (word[i]) begin
                ln.push_back(word[i]);
            end
            nargs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : wanted_args[k];
            for (int j = 0; j < nargs; j++) begin
                ln.push_back(dcld_pkg::CH_CR);
                if ($urandom_range(0, 3) == 0) begin
                    ln.push_back(dcld_pkg::CH_CR);
                end
                if ($urandom_range(0, 3) == 0) begin
                    ln.push_back(dcld_pkg::CH_LF);
                end
                repeat ($urandom_range(1, 6)) ln.push_back(plain_byte());
            end
            case ($urandom_range(0, 3))
                0: ;
                1: ln.push_back(dcld_pkg::CH_CR);
                2: ln.push_back(dcld_pkg::CH_LF);
                default: begin
                    ln.push_back(dcld_pkg::CH_CR);
                    ln.push_back(dcld_pkg::CH_LF);
                end
            endcase
        end else begin
            // Without many carriage returns the noise often makes an overlong command.
            cr_heavy = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 40)) begin
                r = $urandom_range(0, 9);
                if (cr_heavy && r < 2) begin
                    ln.push_back(dcld_pkg::CH_CR);
                end else if (cr_heavy && r == 2) begin
                    ln.push_back(dcld_pkg::CH_LF);
                end else begin
                    ln.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        return queue_line(ln);
    endfunction

    function automatic string show(input dcld_pkg::result_t r);
        return $sformatf("kind=%0d idx=%0d byte=%02h code=%0d status=%0d last=%0d",
                         r.result_kind, r.arg_index, r.arg_byte, r.command_code,
                         r.status, r.last_of_run);
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // Driver: the predictor runs on every accepted transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_line_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (line_bytes.size() > 0 && !take_break()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= line_bytes[0].data;
                    s_tlast  <= line_bytes[0].eol;
                    void'(line_bytes.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        dcld_pkg::result_t got;
        dcld_pkg::result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.result_kind  = m_tuser;
                got.arg_index    = m_tdata[0];
                got.arg_byte     = m_tdata[8:1];
                got.command_code = m_tdata[13:9];
                got.status       = m_tdata[15:14];
                got.last_of_run  = m_tlast;
                if (due_results.size() == 0) begin
                    note_failure({"result with nothing due: ", show(got)});
                end else begin
                    want = due_results.pop_front();
                    if (got.result_kind !== want.result_kind
                            || got.arg_index !== want.arg_index
                            || got.arg_byte !== want.arg_byte
                            || got.command_code !== want.command_code
                            || got.status !== want.status
                            || got.last_of_run !== want.last_of_run) begin
                        note_failure({"mismatch, expected ", show(want), " got ", show(got)});
                    end
                end
            end
            m_tready <= !take_break();
        end
    end

    initial begin
        int total;
        byte unsigned extremes [$];
        clear_line_state();

        total = 0;
        total += queue_text("\n");
        total += queue_text("\015");
        // Skipped newline after a return, an empty token, and an argument byte at line end.
        total += queue_text("say\015\nx\015\015y");
        extremes = '{8'hFF, dcld_pkg::CH_CR, 8'h00};
        total += queue_line(extremes);
        // Too many arguments, and a final newline.
        total += queue_text("a\015b\015c\015d\n");
        // The second newline after a return is an ordinary argument byte.
        total += queue_text("nick\015\n\nz");

        total = 0;
        while (total < LINE_BYTE_TARGET) begin
            total += queue_random_line();
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (line_bytes.size() != 0 || s_tvalid) @(negedge aclk);
        while (due_results.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (due_results.size() != 0) begin
            note_failure("results still due at the end of the run");
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
